// ----- sv/tslb_pkg.sv -----
// shared types and constants for the two-ship loading search block
// no dependencies; used by every module of the block
`default_nettype none

package tslb_pkg;

    localparam int MAX_ITEMS   = 16;
    localparam int WEIGHT_BITS = 12;
    localparam int WEIGHT_W    = 12;
    localparam int LOAD_W      = 16;
    localparam int MASK_W      = 16;
    localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CAP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CAP = 1'b1;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } item_t;

    typedef struct packed {
        logic              solvable;
        logic [LOAD_W-1:0] first_ship_load;
        logic [MASK_W-1:0] first_ship_mask;
        logic [4:0]        container_count;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [LOAD_W-1:0]  total;
        logic               dropped;
    } store_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DOWN,
        S_UP,
        S_SKIP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- sv/tslb_store.sv -----
// container weight store with fill count, running total and drop flag
// depends on tslb_pkg
`default_nettype none

module tslb_store (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [tslb_pkg::WEIGHT_W-1:0]  wr_weight,
    input  wire logic                           clear,
    input  wire logic [tslb_pkg::IDX_W-1:0]     rd_idx,
    output      logic [tslb_pkg::WEIGHT_BITS-1:0] rd_weight,
    output      tslb_pkg::store_status_t        status
);

    logic [tslb_pkg::WEIGHT_BITS-1:0] mem [tslb_pkg::MAX_ITEMS];

    logic [tslb_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [tslb_pkg::LOAD_W-1:0]  total_reg, total_next;
    logic                         dropped_reg, dropped_next;
    logic                         room;
    logic [tslb_pkg::WEIGHT_BITS-1:0] w_in;
    logic [tslb_pkg::WEIGHT_BITS-1:0] rd_weight_reg;

    assign w_in = wr_weight[tslb_pkg::WEIGHT_BITS-1:0];
    assign room = count_reg != tslb_pkg::COUNT_W'(tslb_pkg::MAX_ITEMS);

    // registered read, the search presents the address in the cycle before the weight is used
    always_ff @(posedge clk)
    begin
        if (wr_en && room)
        begin
            mem[count_reg[tslb_pkg::IDX_W-1:0]] <= w_in;
        end
        rd_weight_reg <= mem[rd_idx];
    end

    assign rd_weight = rd_weight_reg;

    always_comb
    begin
        count_next   = count_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        if (clear)
        begin
            count_next   = '0;
            total_next   = '0;
            dropped_next = 1'b0;
        end
        else if (wr_en)
        begin
            if (room)
            begin
                count_next = count_reg + tslb_pkg::COUNT_W'(1);
                total_next = total_reg + tslb_pkg::LOAD_W'(w_in);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
        end
    end

    assign status.count   = count_reg;
    assign status.total   = total_reg;
    assign status.dropped = dropped_reg;

endmodule

`default_nettype wire

// ----- sv/tslb_search.sv -----
// backtracking search sequencer around one shared adder and compare
// depends on tslb_pkg; reads weights from tslb_store
`default_nettype none

module tslb_search (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             go,
    input  wire logic [tslb_pkg::CFG_W-1:0]       first_cap,
    input  wire tslb_pkg::store_status_t          status,
    input  wire logic [tslb_pkg::WEIGHT_BITS-1:0] rd_weight,
    output      logic [tslb_pkg::IDX_W-1:0]       rd_idx,
    output      logic                             busy,
    output      logic                             done,
    output      logic [tslb_pkg::LOAD_W-1:0]      best_load,
    output      logic [tslb_pkg::MASK_W-1:0]      best_choice
);

    tslb_pkg::state_t state_reg, state_next;

    logic [tslb_pkg::COUNT_W-1:0] lvl_reg, lvl_next;
    logic [tslb_pkg::LOAD_W-1:0]  cur_reg, cur_next;
    logic [tslb_pkg::LOAD_W-1:0]  rem_reg, rem_next;
    logic [tslb_pkg::LOAD_W-1:0]  best_reg, best_next;
    logic [tslb_pkg::MASK_W-1:0]  curc_reg, curc_next;
    logic [tslb_pkg::MASK_W-1:0]  bestc_reg, bestc_next;

    logic [tslb_pkg::LOAD_W-1:0]  w;
    logic [tslb_pkg::MASK_W-1:0]  bit_m;
    logic [tslb_pkg::LOAD_W:0]    add_b, add_sum, cmp_ref;
    logic                         le_ref;
    logic                         at_end;
    logic                         at_root;
    logic                         taken;

    // next level goes to the store so the weight of the current level is ready
    assign rd_idx  = lvl_next[tslb_pkg::IDX_W-1:0];
    assign w       = tslb_pkg::LOAD_W'(rd_weight);
    assign bit_m   = tslb_pkg::MASK_W'(1) << lvl_reg[tslb_pkg::IDX_W-1:0];
    assign at_end  = lvl_reg >= status.count;
    assign at_root = lvl_reg == '0;
    assign taken   = (curc_reg & bit_m) != '0;

    // shared unit: take test in DOWN, skip bound test in SKIP
    always_comb
    begin
        if (state_reg == tslb_pkg::S_SKIP)
        begin
            add_b   = {1'b0, rem_reg};
            cmp_ref = {1'b0, best_reg};
        end
        else
        begin
            add_b   = {1'b0, w};
            cmp_ref = {1'b0, first_cap};
        end
    end

    assign add_sum = {1'b0, cur_reg} + add_b;
    assign le_ref  = add_sum <= cmp_ref;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tslb_pkg::S_IDLE:
            begin
                if (go)
                begin
                    state_next = tslb_pkg::S_INIT;
                end
            end
            tslb_pkg::S_INIT:
            begin
                state_next = tslb_pkg::S_DOWN;
            end
            tslb_pkg::S_DOWN:
            begin
                if (at_end)
                begin
                    state_next = at_root ? tslb_pkg::S_DONE : tslb_pkg::S_UP;
                end
                else if (!le_ref)
                begin
                    state_next = tslb_pkg::S_SKIP;
                end
            end
            tslb_pkg::S_UP:
            begin
                if (taken)
                begin
                    state_next = tslb_pkg::S_SKIP;
                end
                else if (at_root)
                begin
                    state_next = tslb_pkg::S_DONE;
                end
            end
            tslb_pkg::S_SKIP:
            begin
                if (!le_ref)
                begin
                    state_next = tslb_pkg::S_DOWN;
                end
                else
                begin
                    state_next = at_root ? tslb_pkg::S_DONE : tslb_pkg::S_UP;
                end
            end
            tslb_pkg::S_DONE:
            begin
                state_next = tslb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tslb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lvl_next   = lvl_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        best_next  = best_reg;
        curc_next  = curc_reg;
        bestc_next = bestc_reg;
        case (state_reg)
            tslb_pkg::S_INIT:
            begin
                lvl_next   = '0;
                cur_next   = '0;
                rem_next   = status.total;
                best_next  = '0;
                curc_next  = '0;
                bestc_next = '0;
            end
            tslb_pkg::S_DOWN:
            begin
                if (at_end)
                begin
                    if (cur_reg > best_reg)
                    begin
                        best_next  = cur_reg;
                        bestc_next = curc_reg;
                    end
                    if (!at_root)
                    begin
                        lvl_next = lvl_reg - tslb_pkg::COUNT_W'(1);
                    end
                end
                else
                begin
                    rem_next = rem_reg - w;
                    if (le_ref)
                    begin
                        cur_next  = add_sum[tslb_pkg::LOAD_W-1:0];
                        curc_next = curc_reg | bit_m;
                        lvl_next  = lvl_reg + tslb_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        curc_next = curc_reg & ~bit_m;
                    end
                end
            end
            tslb_pkg::S_UP:
            begin
                if (taken)
                begin
                    cur_next  = cur_reg - w;
                    curc_next = curc_reg & ~bit_m;
                end
                else
                begin
                    rem_next = rem_reg + w;
                    if (!at_root)
                    begin
                        lvl_next = lvl_reg - tslb_pkg::COUNT_W'(1);
                    end
                end
            end
            tslb_pkg::S_SKIP:
            begin
                if (!le_ref)
                begin
                    lvl_next = lvl_reg + tslb_pkg::COUNT_W'(1);
                end
                else
                begin
                    rem_next = rem_reg + w;
                    if (!at_root)
                    begin
                        lvl_next = lvl_reg - tslb_pkg::COUNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy = state_reg != tslb_pkg::S_IDLE;
        done = state_reg == tslb_pkg::S_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tslb_pkg::S_IDLE;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        rem_reg   <= rem_next;
        best_reg  <= best_next;
        curc_reg  <= curc_next;
        bestc_reg <= bestc_next;
    end

    assign best_load   = best_reg;
    assign best_choice = bestc_reg;

endmodule

`default_nettype wire

// ----- sv/two_ship_loading_backtrack.sv -----
// top level: capacity registers, weight store and backtracking search
// depends on tslb_pkg, tslb_store and tslb_search
//
//   channel   handshake            word
//   input     start & !busy        item   (weight, last)
//   result    done, one cycle      result (solvable, load, mask, count, overflow)
//   config    cfg_we               cfg_idx, cfg_data
//
// a weight not marked last is written to the store and busy stays low
// a last weight starts the search: an init state, then the steps of the
// search sequencer (take test, back-up or skip test), then a result state
// the number of steps follows the search tree
// reset clears the capacities, the fill count and the sequencer
// results cannot be stalled; done is high for exactly one cycle
`default_nettype none

module two_ship_loading_backtrack (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire tslb_pkg::item_t                item,
    output      logic                           done,
    output      tslb_pkg::result_t              result,
    input  wire logic                           cfg_we,
    input  wire logic [tslb_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [tslb_pkg::CFG_W-1:0]     cfg_data
);

    logic [tslb_pkg::CFG_W-1:0] first_cap_reg;
    logic [tslb_pkg::CFG_W-1:0] second_cap_reg;

    tslb_pkg::store_status_t          status;
    logic [tslb_pkg::WEIGHT_BITS-1:0] rd_weight;
    logic [tslb_pkg::IDX_W-1:0]       rd_idx;
    logic [tslb_pkg::LOAD_W-1:0]      best_load;
    logic [tslb_pkg::MASK_W-1:0]      best_choice;
    logic [tslb_pkg::LOAD_W-1:0]      leftover;
    logic                             accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cap_reg  <= '0;
            second_cap_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                tslb_pkg::CFG_FIRST_CAP:  first_cap_reg  <= cfg_data;
                tslb_pkg::CFG_SECOND_CAP: second_cap_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tslb_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_weight (item.weight),
        .clear     (done),
        .rd_idx    (rd_idx),
        .rd_weight (rd_weight),
        .status    (status)
    );

    tslb_search u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (accept && item.last),
        .first_cap   (first_cap_reg),
        .status      (status),
        .rd_weight   (rd_weight),
        .rd_idx      (rd_idx),
        .busy        (busy),
        .done        (done),
        .best_load   (best_load),
        .best_choice (best_choice)
    );

    assign leftover = status.total - best_load;

    always_comb
    begin
        result.solvable        = leftover <= second_cap_reg;
        result.first_ship_load = best_load;
        result.first_ship_mask = best_choice;
        result.container_count = 5'(status.count);
        result.overflow        = status.dropped;
    end

endmodule

`default_nettype wire

// ----- tb/two_ship_loading_backtrack_tb.sv -----
// testbench for two_ship_loading_backtrack: directed table, then random batches
// of container weights checked word by word against a built-in search predictor
// depends on tslb_pkg and two_ship_loading_backtrack
module two_ship_loading_backtrack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    PHASES          = 40;
    localparam int    ITEMS_PER_PHASE = 40;
    localparam longint CYCLE_LIMIT    = 200_000_000;

    typedef enum {ROW_WORD, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t                              kind;
        tslb_pkg::item_t                        word;
        bit                                     typed;
        tslb_pkg::result_t                      res;
        logic [tslb_pkg::CFG_IDX_W-1:0]         idx;
        logic [tslb_pkg::CFG_W-1:0]             val;
    } row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    tslb_pkg::item_t                item;
    logic                           done;
    tslb_pkg::result_t              result;
    logic                           cfg_we;
    logic [tslb_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [tslb_pkg::CFG_W-1:0]     cfg_data;

    // predictor state
    logic [tslb_pkg::WEIGHT_W-1:0]  bay_weights [tslb_pkg::MAX_ITEMS];
    int                             bay_fill;
    bit                             bay_dropped;
    logic [tslb_pkg::CFG_W-1:0]     first_cap;
    logic [tslb_pkg::CFG_W-1:0]     second_cap;

    tslb_pkg::result_t              pending_plans [$];
    int                             mismatches;
    longint                         cycles;
    bit                             burst;
    row_t                           rows [$];

    two_ship_loading_backtrack DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // take-first depth-first search with the remaining-weight bound
    function automatic void search_plan(output logic [tslb_pkg::LOAD_W-1:0] best_out,
                                        output logic [tslb_pkg::MASK_W-1:0] pick_out,
                                        output int unsigned total);
        int          n;
        int          lvl;
        int unsigned load;
        int unsigned rest;
        int unsigned best;
        int unsigned w;
        logic [tslb_pkg::MASK_W-1:0] chosen;
        bit          down;
        bit          try_skip;

        n = bay_fill;
        load = 0;
        best = 0;
        rest = 0;
        chosen = '0;
        pick_out = '0;
        for (int k = 0; k < n; k++)
            rest += 32'(bay_weights[k]);
        total = rest;
        lvl = 0;
        down = 1'b1;
        while (lvl >= 0)
        begin
            if (down && lvl >= n)
            begin
                if (load > best)
                begin
                    best = load;
                    pick_out = chosen;
                end
                down = 1'b0;
                lvl--;
            end
            else
            begin
                w = 32'(bay_weights[lvl]);
                try_skip = 1'b0;
                if (down)
                begin
                    rest -= w;
                    chosen[lvl] = 1'b0;
                    if (load + w <= 32'(first_cap))
                    begin
                        load += w;
                        chosen[lvl] = 1'b1;
                        lvl++;
                    end
                    else
                        try_skip = 1'b1;
                end
                else if (chosen[lvl])
                begin
                    load -= w;
                    chosen[lvl] = 1'b0;
                    try_skip = 1'b1;
                end
                else
                begin
                    rest += w;
                    lvl--;
                end
                if (try_skip)
                begin
                    if (load + rest > best)
                    begin
                        down = 1'b1;
                        lvl++;
                    end
                    else
                    begin
                        rest += w;
                        down = 1'b0;
                        lvl--;
                    end
                end
            end
        end
        best_out = best[tslb_pkg::LOAD_W-1:0];
    endfunction

    // store one weight; on the closing word work out the plan
    function automatic bit plan_load(input tslb_pkg::item_t w,
                                     output tslb_pkg::result_t plan);
        logic [tslb_pkg::LOAD_W-1:0] best;
        logic [tslb_pkg::MASK_W-1:0] pick;
        int unsigned                 total;

        plan = '0;
        if (bay_fill < tslb_pkg::MAX_ITEMS)
        begin
            bay_weights[bay_fill] = w.weight;
            bay_fill++;
        end
        else
            bay_dropped = 1'b1;
        if (!w.last)
            return 1'b0;
        search_plan(best, pick, total);
        plan.solvable        = (total - 32'(best) <= 32'(second_cap));
        plan.first_ship_load = best;
        plan.first_ship_mask = pick;
        plan.container_count = bay_fill[4:0];
        plan.overflow        = bay_dropped;
        bay_fill = 0;
        bay_dropped = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_row(input row_t r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic void add_plan(input tslb_pkg::result_t p);
        pending_plans.insert(pending_plans.size(), p);
    endfunction

    function automatic row_t word_row(input int unsigned wt, input bit lst);
        row_t r;
        r = '{kind: ROW_WORD, word: '0, typed: 1'b0, res: '0, idx: '0, val: '0};
        r.word.weight = wt[tslb_pkg::WEIGHT_W-1:0];
        r.word.last = lst;
        return r;
    endfunction

    function automatic row_t checked_row(input int unsigned wt, input bit lst,
                                         input tslb_pkg::result_t res);
        row_t r;
        r = word_row(wt, lst);
        r.typed = 1'b1;
        r.res = res;
        return r;
    endfunction

    function automatic row_t cap_row(input logic [tslb_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [tslb_pkg::CFG_W-1:0] val);
        row_t r;
        r = '{kind: ROW_CAP, word: '0, typed: 1'b0, res: '0, idx: idx, val: val};
        return r;
    endfunction

    task automatic send_word(input tslb_pkg::item_t w, input bit typed,
                             input tslb_pkg::result_t typed_res);
        int                gap;
        tslb_pkg::result_t plan;

        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (plan_load(w, plan))
            add_plan(typed ? typed_res : plan);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_plans.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [tslb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tslb_pkg::CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == tslb_pkg::CFG_FIRST_CAP)
            first_cap = val;
        else
            second_cap = val;
    endtask

    function automatic logic [tslb_pkg::CFG_W-1:0] pick_capacity(
        input int unsigned weight_top);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return tslb_pkg::CFG_W'($urandom_range(0, 65535));
            default: return tslb_pkg::CFG_W'($urandom_range(0, 4 * weight_top));
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            $display("%0t %s: expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_plans.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected word: expected none, got %0h", $time, result);
            end
            else
            begin
                tslb_pkg::result_t exp_plan;
                exp_plan = pending_plans.pop_front();
                check_field("solvable", 16'(exp_plan.solvable), 16'(result.solvable));
                check_field("first_ship_load", exp_plan.first_ship_load,
                            result.first_ship_load);
                check_field("first_ship_mask", exp_plan.first_ship_mask,
                            result.first_ship_mask);
                check_field("container_count", 16'(exp_plan.container_count),
                            16'(result.container_count));
                check_field("overflow", 16'(exp_plan.overflow), 16'(result.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        tslb_pkg::item_t w;
        int              sent;
        int              size;
        int unsigned     weight_top;

        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        first_cap  = '0;
        second_cap = '0;
        bay_fill   = 0;
        bay_dropped = 1'b0;
        mismatches = 0;
        cycles     = 0;
        burst      = 1'b0;
        for (int k = 0; k < tslb_pkg::MAX_ITEMS; k++)
            bay_weights[k] = '0;

        // capacities still at reset
        add_row(checked_row(0, 1'b1, '{1'b1, 16'd0, 16'h0000, 5'd1, 1'b0}));
        add_row(checked_row(4095, 1'b1, '{1'b0, 16'd0, 16'h0000, 5'd1, 1'b0}));
        add_row(cap_row(tslb_pkg::CFG_FIRST_CAP, 16'hffff));
        add_row(cap_row(tslb_pkg::CFG_SECOND_CAP, 16'hffff));
        add_row(word_row(4095, 1'b0));
        add_row(checked_row(4095, 1'b1, '{1'b1, 16'd8190, 16'h0003, 5'd2, 1'b0}));
        // full store, closing word dropped
        for (int k = 0; k < tslb_pkg::MAX_ITEMS; k++)
            add_row(word_row(4095, 1'b0));
        add_row(checked_row(4095, 1'b1, '{1'b1, 16'd65520, 16'hffff, 5'd16, 1'b1}));
        // batch state cleared
        add_row(checked_row(1, 1'b1, '{1'b1, 16'd1, 16'h0001, 5'd1, 1'b0}));
        add_row(cap_row(tslb_pkg::CFG_FIRST_CAP, 16'd10));
        add_row(cap_row(tslb_pkg::CFG_SECOND_CAP, 16'd0));
        add_row(word_row(6, 1'b0));
        add_row(word_row(5, 1'b0));
        add_row(checked_row(4, 1'b1, '{1'b0, 16'd10, 16'h0005, 5'd3, 1'b0}));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CAP)
            begin
                drain();
                write_capacity(rows[i].idx, rows[i].val);
            end
            else
                send_word(rows[i].word, rows[i].typed, rows[i].res);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 2))
                0:       weight_top = 63;
                1:       weight_top = 511;
                default: weight_top = 4095;
            endcase
            drain();
            write_capacity(tslb_pkg::CFG_FIRST_CAP, pick_capacity(weight_top));
            write_capacity(tslb_pkg::CFG_SECOND_CAP, pick_capacity(weight_top));
            burst = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:1]:   size = $urandom_range(tslb_pkg::MAX_ITEMS,
                                                   tslb_pkg::MAX_ITEMS + 2);
                    [2:14]:  size = $urandom_range(9, 12);
                    default: size = $urandom_range(1, 8);
                endcase
                for (int k = 0; k < size; k++)
                begin
                    w.weight = ($urandom_range(0, 3) == 0)
                             ? tslb_pkg::WEIGHT_W'($urandom_range(0, 4095))
                             : tslb_pkg::WEIGHT_W'($urandom_range(0, weight_top));
                    w.last = (k == size - 1);
                    send_word(w, 1'b0, '0);
                end
                sent += size;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_plans.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
